/* design/ukvt_pkg.sv */
// ----------------------------------------------------------------------------
// ukvt_pkg
// Shared command codes and the link, broadcast and commit types of the
// key/value table cell chain.
// ----------------------------------------------------------------------------
package ukvt_pkg;

	localparam int KEY_W  = 32;
	localparam int DATA_W = 32;
	localparam int CNT_OUT_W = 7;

	typedef enum logic [1:0] {
		CMD_INSERT   = 2'd0,
		CMD_REMOVE   = 2'd1,
		CMD_CONTAINS = 2'd2,
		CMD_UPDATE   = 2'd3
	} cmd_t;

	typedef struct packed {
		logic tok;
		logic hit;
		logic claimed;
	} link_t;

	typedef struct packed {
		logic              is_insert;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] value;
	} bcast_t;

	typedef struct packed {
		logic strobe;
		logic insert_en;
		logic remove_en;
		logic update_en;
	} commit_t;

endpackage

/* design/unique_key_value_table_top.sv */
// ----------------------------------------------------------------------------
// Flow: a command is registered and its search token walks the cell chain one
// entry per cycle; after the token leaves the last cell, the response is
// registered, later while a previous response stalls. Requests stall until then.
// Reset: asynchronous and active low; all entries become unused and the count
// is zero, with the block ready for a request at once.
// ----------------------------------------------------------------------------
// unique_key_value_table_top
// Unique key/value table built as a chain of entry cells with a sequencer.
// ----------------------------------------------------------------------------
module unique_key_value_table_top
	import ukvt_pkg::*;
#(
	parameter int CAPACITY = 64
)
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic [1:0]               command,
	input  logic signed [KEY_W-1:0]  key,
	input  logic [DATA_W-1:0]        value,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output logic                     status,
	output logic                     found,
	output logic [CNT_OUT_W-1:0]     entry_count
);

	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} state_t;

	state_t               state_q;
	cmd_t                 cmd_q;
	bcast_t               bcast_q;
	commit_t              commit_q;
	logic                 start_q;
	logic                 hit_q;
	logic                 claimed_q;
	logic [CW-1:0]        count_q;
	logic                 rsp_valid_q;
	logic                 status_q;
	logic                 found_q;
	logic [CNT_OUT_W-1:0] entry_count_q;

	link_t                chain [CAPACITY+1];

	logic                 ins_ok;
	logic                 rem_ok;
	logic                 upd_ok;
	logic [CW-1:0]        count_next;
	logic [CW+CNT_OUT_W-1:0] count_ext;

	assign chain[0] = '{tok: start_q, hit: 1'b0, claimed: 1'b0};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ukvt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.bcast     (bcast_q),
			.commit    (commit_q),
			.prev_link (chain[i]),
			.next_link (chain[i+1])
		);
	end

	assign ins_ok = (cmd_q == CMD_INSERT) && !hit_q && claimed_q;
	assign rem_ok = (cmd_q == CMD_REMOVE) && hit_q;
	assign upd_ok = (cmd_q == CMD_UPDATE) && hit_q && (bcast_q.value != '0);

	always_comb begin
		count_next = count_q;
		if (ins_ok) begin
			count_next = count_q + CW'(1);
		end else if (rem_ok && (count_q != '0)) begin
			count_next = count_q - CW'(1);
		end
	end

	assign count_ext = {{CNT_OUT_W{1'b0}}, count_next};

	assign req_stall   = (state_q != ST_IDLE);
	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign found       = found_q;
	assign entry_count = entry_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cmd_q         <= CMD_INSERT;
			bcast_q       <= '0;
			commit_q      <= '0;
			start_q       <= 1'b0;
			hit_q         <= 1'b0;
			claimed_q     <= 1'b0;
			count_q       <= '0;
			rsp_valid_q   <= 1'b0;
			status_q      <= 1'b0;
			found_q       <= 1'b0;
			entry_count_q <= '0;
		end else begin
			commit_q <= '0;
			start_q  <= 1'b0;
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						cmd_q             <= cmd_t'(command);
						bcast_q.is_insert <= (cmd_t'(command) == CMD_INSERT);
						bcast_q.key       <= $unsigned(key);
						bcast_q.value     <= value;
						start_q           <= 1'b1;
						state_q           <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (chain[CAPACITY].tok) begin
						hit_q     <= chain[CAPACITY].hit;
						claimed_q <= chain[CAPACITY].claimed;
						state_q   <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!rsp_valid_q || !rsp_stall) begin
						commit_q.strobe    <= 1'b1;
						commit_q.insert_en <= ins_ok;
						commit_q.remove_en <= rem_ok;
						commit_q.update_en <= upd_ok;
						count_q            <= count_next;
						status_q           <= !(ins_ok || rem_ok || upd_ok ||
							(cmd_q == CMD_CONTAINS));
						found_q            <= hit_q;
						entry_count_q      <= count_ext[CNT_OUT_W-1:0];
						rsp_valid_q        <= 1'b1;
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* design/ukvt_cell.sv */
// ----------------------------------------------------------------------------
// ukvt_cell
// One table entry. It compares its key with the broadcast key, passes the
// search token to the next cell and applies the commit of a command.
// ----------------------------------------------------------------------------
module ukvt_cell
	import ukvt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  bcast_t  bcast,
	input  commit_t commit,
	input  link_t   prev_link,
	output link_t   next_link
);

	logic              used_q;
	logic              pend_q;
	logic [KEY_W-1:0]  key_q;
	logic [DATA_W-1:0] data_q;
	link_t             link_q;
	logic              match;
	logic              is_free;

	assign match     = used_q && (key_q == bcast.key);
	assign is_free   = !used_q;
	assign next_link = link_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			pend_q <= 1'b0;
			link_q <= '0;
		end else begin
			link_q.tok     <= prev_link.tok;
			link_q.hit     <= prev_link.tok & (prev_link.hit | match);
			link_q.claimed <= prev_link.tok &
				(prev_link.claimed | (bcast.is_insert & is_free));
			if (prev_link.tok && bcast.is_insert && is_free && !prev_link.claimed) begin
				pend_q <= 1'b1;
			end
			if (commit.strobe) begin
				pend_q <= 1'b0;
				if (commit.insert_en && pend_q) begin
					used_q <= 1'b1;
				end
				if (commit.remove_en && match) begin
					used_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit.strobe && commit.insert_en && pend_q) begin
			key_q  <= bcast.key;
			data_q <= bcast.value;
		end else if (commit.strobe && commit.update_en && match) begin
			data_q <= bcast.value;
		end
	end

endmodule

/* design/ukvt_checker.sv */
// ----------------------------------------------------------------------------
// ukvt_checker
// Port-level checks of the key/value table responses, bound to the top level.
// ----------------------------------------------------------------------------
module ukvt_checker
	import ukvt_pkg::*;
#(
	parameter int CAPACITY = 64
)
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     rsp_valid,
	input logic                     rsp_stall,
	input logic                     status,
	input logic                     found,
	input logic [CNT_OUT_W-1:0]     entry_count
);

	logic [CNT_OUT_W-1:0] prev_count_q;
	logic                 rsp_xfer;

	assign rsp_xfer = rsp_valid && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_count_q <= '0;
		end else if (rsp_xfer) begin
			prev_count_q <= entry_count;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(found) &&
			$stable(entry_count))
		else $error("Stalled response changed before its transfer.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (CAPACITY > 127) || (int'(entry_count) <= CAPACITY))
		else $error("Entry count exceeds the table capacity.");

	a_fail_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_xfer && status |-> entry_count == prev_count_q)
		else $error("A failed command changed the entry count.");

	a_miss_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_xfer && !found |-> (entry_count == prev_count_q) ||
			(entry_count == CNT_OUT_W'(prev_count_q + 1'b1)))
		else $error("A command on an absent key moved the count wrongly.");

	a_hit_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_xfer && found |-> (entry_count == prev_count_q) ||
			(entry_count == CNT_OUT_W'(prev_count_q - 1'b1)))
		else $error("A command on a held key moved the count wrongly.");

endmodule

bind unique_key_value_table_top ukvt_checker #(.CAPACITY(CAPACITY)) u_ukvt_checker (.*);
